### hw/rtl/bcht_pkg.sv
`default_nettype none
package bcht_pkg;

    localparam logic [3:0] MODE_REGISTER  = 4'd0;
    localparam logic [3:0] MODE_SET_STATE = 4'd1;
    localparam logic [3:0] MODE_REPORT    = 4'd2;
    localparam logic [3:0] MODE_RECOVERY  = 4'd3;
    localparam logic [3:0] MODE_GLOBAL    = 4'd4;
    localparam logic [3:0] MODE_TICK      = 4'd5;
    localparam logic [3:0] MODE_QUERY     = 4'd6;
    localparam logic [3:0] MODE_INIT      = 4'd7;
    localparam logic [3:0] MODE_SHUTDOWN  = 4'd8;

    localparam logic [2:0] ST_UNINIT  = 3'd0;
    localparam logic [2:0] ST_ACTIVE  = 3'd1;
    localparam logic [2:0] ST_PASSIVE = 3'd2;
    localparam logic [2:0] ST_BUS_OFF = 3'd3;
    localparam logic [2:0] ST_FAILURE = 3'd4;

    localparam logic [1:0] REG_CAN_LIMIT = 2'd0;
    localparam logic [1:0] REG_LIN_LIMIT = 2'd1;
    localparam logic [1:0] REG_CAN_TYPE  = 2'd2;
    localparam logic [1:0] REG_LIN_TYPE  = 2'd3;

    localparam logic [4:0] MAX_EVENTS = 5'd16;

    typedef struct packed {
        logic [3:0]  mode;
        logic [7:0]  chan_type;
        logic [7:0]  chan_id;
        logic [2:0]  wanted_state;
        logic [31:0] now_ms;
        logic        auto_recover;
        logic [31:0] recover_after_ms;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [7:0]  out_type;
        logic [7:0]  out_id;
        logic [2:0]  link_state;
        logic [31:0] error_total;
        logic        found;
        logic        table_full;
        logic [4:0]  used_slots;
        logic [2:0]  overall_state;
        logic        last;
    } t_out;

    typedef struct packed {
        logic        valid;
        logic [7:0]  chan_type;
        logic [7:0]  chan_id;
        logic [2:0]  state;
        logic [31:0] errors;
        logic [31:0] change_time;
        logic        auto_rec;
        logic [31:0] recover_time;
    } t_rec;

endpackage
`default_nettype wire

### hw/rtl/bcht_cell.sv
`default_nettype none
module bcht_cell
    import bcht_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_shift,
    input  wire t_rec i_d,
    output t_rec      o_q
);

    t_rec r_q;

    // only the valid bit is control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

### hw/rtl/bus_channel_health_table.sv
// channel   direction  handshake                    payload
// in        input      i_in_valid / o_in_ready      i_in  (t_in)
// out       output     o_out_valid / i_out_ready    o_out (t_out)
// cfg       input      psel penable pwrite pready    paddr pwdata prdata
//
// one request takes two walks round the ring of CHANNELS cells (lookup, then
// apply), after an idle state that takes it and before a reply state; during
// the walks the ring moves one slot past the head cell per cycle unless stalled
// reset is synchronous and empties the table; no clearing pass is needed
// the apply walk halts while an event waits for the output register to free
`default_nettype none
module bus_channel_health_table
    import bcht_pkg::*;
#(
    parameter int CHANNELS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in         i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out             o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW = $clog2(CHANNELS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(CHANNELS - 1);

    // controller states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOOK  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;
    localparam logic [1:0] S_REPLY = 2'd3;

    // configuration registers
    logic [15:0] r_can_limit, r_lin_limit;
    logic [7:0]  r_can_type, r_lin_type;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_can_limit <= 16'd255;
            r_lin_limit <= 16'd31;
            r_can_type  <= 8'd0;
            r_lin_type  <= 8'd1;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_CAN_LIMIT: r_can_limit <= pwdata[15:0];
                REG_LIN_LIMIT: r_lin_limit <= pwdata[15:0];
                REG_CAN_TYPE:  r_can_type  <= pwdata[7:0];
                REG_LIN_TYPE:  r_lin_type  <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CAN_LIMIT: prdata = {16'd0, r_can_limit};
            REG_LIN_LIMIT: prdata = {16'd0, r_lin_limit};
            REG_CAN_TYPE:  prdata = {24'd0, r_can_type};
            REG_LIN_TYPE:  prdata = {24'd0, r_lin_type};
        endcase
    end

    // controller registers
    logic [1:0]    r_state, n_state;
    t_in           r_req, n_req;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_hit, n_hit;
    logic [IW-1:0] r_sidx, n_sidx;
    logic          r_free, n_free;
    logic [IW-1:0] r_fidx, n_fidx;
    logic [CW-1:0] r_count, n_count;
    logic [4:0]    r_evcnt, n_evcnt;
    logic [2:0]    r_global, n_global;
    logic          r_running, n_running;
    logic          r_rep_found, n_rep_found;
    logic [2:0]    r_rep_state, n_rep_state;
    logic [31:0]   r_rep_errors, n_rep_errors;
    logic          r_out_valid, n_out_valid;
    t_out          r_out, n_out;

    // ring of cells, cell 0 is the head
    t_rec cq [CHANNELS];
    t_rec ring_in;
    logic shift;

    for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
        t_rec d;
        if (g == CHANNELS - 1) begin : g_tail
            assign d = ring_in;
        end else begin : g_mid
            assign d = cq[g + 1];
        end
        bcht_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_d     (d),
            .o_q     (cq[g])
        );
    end

    t_rec        head, nrec;
    logic        chg, ev_fire, stall, out_free, match;
    logic [2:0]  tgt;
    logic [31:0] errs_inc, elapsed, cnt32;
    logic [4:0]  used5;
    logic        full_flag;

    assign head     = cq[0];
    assign out_free = !r_out_valid || i_out_ready;
    assign match    = head.valid && head.chan_type == r_req.chan_type
                      && head.chan_id == r_req.chan_id;
    assign errs_inc = (head.errors == 32'hFFFF_FFFF) ? head.errors : head.errors + 32'd1;
    assign elapsed  = r_req.now_ms - head.change_time;
    assign cnt32    = 32'(r_count);
    assign used5    = (cnt32 > 32'd31) ? 5'd31 : cnt32[4:0];
    assign full_flag = (r_req.mode == MODE_REGISTER) && !r_hit && !r_free;

    // work on the slot at the head during the apply walk
    always_comb begin
        nrec = head;
        chg  = 1'b0;
        tgt  = head.state;
        unique case (r_req.mode)
            MODE_REGISTER: begin
                if (!r_hit && r_free && r_idx == r_fidx) begin
                    nrec.valid        = 1'b1;
                    nrec.chan_type    = r_req.chan_type;
                    nrec.chan_id      = r_req.chan_id;
                    nrec.state        = ST_ACTIVE;
                    nrec.errors       = 32'd0;
                    nrec.change_time  = 32'd0;
                    nrec.auto_rec     = 1'b0;
                    nrec.recover_time = 32'd0;
                end
            end
            MODE_SET_STATE: begin
                if (r_hit && r_idx == r_sidx && r_req.wanted_state <= ST_FAILURE) begin
                    tgt = r_req.wanted_state;
                    chg = 1'b1;
                end
            end
            MODE_REPORT: begin
                if (r_hit && r_idx == r_sidx) begin
                    nrec.errors = errs_inc;
                    if (r_req.chan_type == r_can_type) begin
                        if (errs_inc > {16'd0, r_can_limit}) begin
                            tgt = ST_BUS_OFF;
                            chg = 1'b1;
                        end
                    end else if (r_req.chan_type == r_lin_type) begin
                        if (errs_inc > {16'd0, r_lin_limit}) begin
                            tgt = ST_PASSIVE;
                            chg = 1'b1;
                        end
                    end else begin
                        tgt = ST_FAILURE;
                        chg = 1'b1;
                    end
                end
            end
            MODE_RECOVERY: begin
                if (r_hit && r_idx == r_sidx) begin
                    nrec.auto_rec     = r_req.auto_recover;
                    nrec.recover_time = r_req.recover_after_ms;
                end
            end
            MODE_GLOBAL: begin
                if (head.valid && r_req.wanted_state <= ST_FAILURE) begin
                    tgt = r_req.wanted_state;
                    chg = 1'b1;
                end
            end
            MODE_TICK: begin
                if (r_running && head.valid && head.auto_rec && head.state == ST_BUS_OFF
                    && elapsed >= head.recover_time) begin
                    nrec.errors = 32'd0;
                    tgt = ST_ACTIVE;
                    chg = 1'b1;
                end
            end
            MODE_SHUTDOWN: nrec.valid = 1'b0;
            default: ;
        endcase
        // equal state is no change
        if (chg && tgt == head.state) begin
            chg = 1'b0;
        end
        if (chg) begin
            nrec.state       = tgt;
            nrec.change_time = r_req.now_ms;
        end
    end

    assign ev_fire = (r_state == S_APPLY) && chg && (r_evcnt < MAX_EVENTS);
    assign stall   = ev_fire && !out_free;
    assign shift   = (r_state == S_LOOK) || ((r_state == S_APPLY) && !stall);
    assign ring_in = (r_state == S_APPLY) ? nrec : head;

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_idx        = r_idx;
        n_hit        = r_hit;
        n_sidx       = r_sidx;
        n_free       = r_free;
        n_fidx       = r_fidx;
        n_count      = r_count;
        n_evcnt      = r_evcnt;
        n_global     = r_global;
        n_running    = r_running;
        n_rep_found  = r_rep_found;
        n_rep_state  = r_rep_state;
        n_rep_errors = r_rep_errors;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in;
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_free  = 1'b0;
                    n_count = '0;
                    n_evcnt = '0;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (match && !r_hit) begin
                    n_hit  = 1'b1;
                    n_sidx = r_idx;
                end
                if (!head.valid && !r_free) begin
                    n_free = 1'b1;
                    n_fidx = r_idx;
                end
                if (head.valid) begin
                    n_count = r_count + CW'(1);
                end
                n_idx = r_idx + IW'(1);
                if (r_idx == LAST_IDX) begin
                    n_idx        = '0;
                    n_rep_found  = 1'b0;
                    n_rep_state  = ST_UNINIT;
                    n_rep_errors = 32'd0;
                    n_state      = S_APPLY;
                    // globals change before any event of the walk
                    unique case (r_req.mode)
                        MODE_GLOBAL: begin
                            if (r_req.wanted_state <= ST_FAILURE) begin
                                n_global = r_req.wanted_state;
                            end
                        end
                        MODE_INIT: begin
                            n_global  = ST_UNINIT;
                            n_running = 1'b1;
                        end
                        MODE_SHUTDOWN: begin
                            n_global  = ST_UNINIT;
                            n_running = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_APPLY: begin
                if (!stall) begin
                    if (ev_fire) begin
                        n_evcnt = r_evcnt + 5'd1;
                        n_out_valid = 1'b1;
                        n_out = '{kind: 1'b1, out_type: head.chan_type,
                                  out_id: head.chan_id, link_state: nrec.state,
                                  error_total: nrec.errors, found: 1'b1,
                                  table_full: 1'b0, used_slots: used5,
                                  overall_state: r_global, last: 1'b0};
                    end
                    // reply fields from the addressed slot after its update
                    if ((r_hit && r_idx == r_sidx)
                        || (r_req.mode == MODE_REGISTER && !r_hit && r_free
                            && r_idx == r_fidx)) begin
                        n_rep_found  = nrec.valid;
                        n_rep_state  = nrec.valid ? nrec.state : ST_UNINIT;
                        n_rep_errors = nrec.valid ? nrec.errors : 32'd0;
                    end
                    n_idx = r_idx + IW'(1);
                    if (r_idx == LAST_IDX) begin
                        n_idx = '0;
                        if (r_req.mode == MODE_SHUTDOWN) begin
                            n_count = '0;
                        end else if (r_req.mode == MODE_REGISTER && !r_hit && r_free) begin
                            n_count = r_count + CW'(1);
                        end
                        n_state = S_REPLY;
                    end
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{kind: 1'b0, out_type: r_req.chan_type,
                              out_id: r_req.chan_id, link_state: r_rep_state,
                              error_total: r_rep_errors, found: r_rep_found,
                              table_full: full_flag, used_slots: used5,
                              overall_state: r_global, last: 1'b1};
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_idx        <= n_idx;
        r_hit        <= n_hit;
        r_sidx       <= n_sidx;
        r_free       <= n_free;
        r_fidx       <= n_fidx;
        r_count      <= n_count;
        r_evcnt      <= n_evcnt;
        r_rep_found  <= n_rep_found;
        r_rep_state  <= n_rep_state;
        r_rep_errors <= n_rep_errors;
        r_out        <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_global    <= ST_UNINIT;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_global    <= n_global;
            r_running   <= n_running;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a waiting result is never dropped by the controller
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid)
        else $error("pending result lost");

    // event budget per request
    a_ev_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_evcnt <= MAX_EVENTS)
        else $error("event count overrun");

    // a stalled apply walk keeps its position
    a_stall_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) && stall |=> $stable(r_idx) && (r_state == S_APPLY))
        else $error("ring moved during stall");

    // only the status reply closes a request
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.last == !r_out.kind))
        else $error("last flag on an event");

endmodule
`default_nettype wire

### tb/bus_channel_health_table_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module bus_channel_health_table_tb;
    import bcht_pkg::*;

    // shadow model of the channel table, with a queue of pending replies
    class health_scoreboard;
        logic [15:0] can_limit;
        logic [15:0] lin_limit;
        logic [7:0]  can_code;
        logic [7:0]  lin_code;
        t_rec        slots [16];
        logic [2:0]  glob;
        bit          running;
        t_out        pending [$];
        int          errors;

        function new();
            can_limit = 16'd255;
            lin_limit = 16'd31;
            can_code  = 8'd0;
            lin_code  = 8'd1;
            glob      = ST_UNINIT;
            running   = 0;
            errors    = 0;
            foreach (slots[i]) slots[i] = '0;
        endfunction

        function logic [4:0] used();
            int n;
            n = 0;
            foreach (slots[i]) if (slots[i].valid) n++;
            return 5'(n);
        endfunction

        function int find(logic [7:0] ty, logic [7:0] id);
            foreach (slots[i])
                if (slots[i].valid && slots[i].chan_type == ty && slots[i].chan_id == id)
                    return i;
            return -1;
        endfunction

        function void push_reply(bit kind, logic [7:0] ty, logic [7:0] id, logic [2:0] st,
                                 logic [31:0] er, bit fnd, bit full, bit lst);
            t_out r;
            r.kind = kind; r.out_type = ty; r.out_id = id; r.link_state = st;
            r.error_total = er; r.found = fnd; r.table_full = full;
            r.used_slots = used(); r.overall_state = glob; r.last = lst;
            pending.push_back(r);
        endfunction

        function void move_state(int s, logic [2:0] st, logic [31:0] now, ref int nev);
            if (slots[s].state == st) return;
            slots[s].state = st;
            slots[s].change_time = now;
            if (nev < 16) begin
                push_reply(1, slots[s].chan_type, slots[s].chan_id, st,
                           slots[s].errors, 1, 0, 0);
                nev++;
            end
        endfunction

        function void note_request(t_in x);
            int s, f, nev;
            bit full;
            nev = 0;
            full = 0;
            s = find(x.chan_type, x.chan_id);
            case (x.mode)
                MODE_REGISTER: begin
                    if (s < 0) begin
                        f = -1;
                        foreach (slots[i]) if (f < 0 && !slots[i].valid) f = i;
                        if (f < 0) full = 1;
                        else begin
                            slots[f] = '0;
                            slots[f].valid = 1;
                            slots[f].chan_type = x.chan_type;
                            slots[f].chan_id = x.chan_id;
                            slots[f].state = ST_ACTIVE;
                        end
                    end
                end
                MODE_SET_STATE: begin
                    if (s >= 0 && x.wanted_state <= ST_FAILURE)
                        move_state(s, x.wanted_state, x.now_ms, nev);
                end
                MODE_REPORT: begin
                    if (s >= 0) begin
                        if (slots[s].errors != 32'hFFFF_FFFF) slots[s].errors++;
                        // can rule wins when both codes match
                        if (x.chan_type == can_code) begin
                            if (slots[s].errors > {16'd0, can_limit})
                                move_state(s, ST_BUS_OFF, x.now_ms, nev);
                        end else if (x.chan_type == lin_code) begin
                            if (slots[s].errors > {16'd0, lin_limit})
                                move_state(s, ST_PASSIVE, x.now_ms, nev);
                        end else begin
                            move_state(s, ST_FAILURE, x.now_ms, nev);
                        end
                    end
                end
                MODE_RECOVERY: begin
                    if (s >= 0) begin
                        slots[s].auto_rec = x.auto_recover;
                        slots[s].recover_time = x.recover_after_ms;
                    end
                end
                MODE_GLOBAL: begin
                    if (x.wanted_state <= ST_FAILURE) begin
                        glob = x.wanted_state;
                        foreach (slots[i])
                            if (slots[i].valid) move_state(i, x.wanted_state, x.now_ms, nev);
                    end
                end
                MODE_TICK: begin
                    if (running)
                        foreach (slots[i])
                            if (slots[i].valid && slots[i].auto_rec
                                && slots[i].state == ST_BUS_OFF
                                && (x.now_ms - slots[i].change_time)
                                   >= slots[i].recover_time) begin
                                slots[i].errors = '0;
                                move_state(i, ST_ACTIVE, x.now_ms, nev);
                            end
                end
                MODE_INIT: begin
                    glob = ST_UNINIT;
                    running = 1;
                end
                MODE_SHUTDOWN: begin
                    running = 0;
                    foreach (slots[i]) slots[i].valid = 0;
                    glob = ST_UNINIT;
                end
                default: ;
            endcase
            s = find(x.chan_type, x.chan_id);
            if (s >= 0)
                push_reply(0, x.chan_type, x.chan_id, slots[s].state, slots[s].errors,
                           1, full, 1);
            else
                push_reply(0, x.chan_type, x.chan_id, ST_UNINIT, 0, 0, full, 1);
        endfunction

        function void check_reply(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                $display("%0t: mismatch, expected %h, actual %h", $time, want, got);
                if (got.kind !== want.kind)
                    $display("  kind expected %0d actual %0d", want.kind, got.kind);
                if (got.link_state !== want.link_state)
                    $display("  state expected %0d actual %0d", want.link_state, got.link_state);
                if (got.error_total !== want.error_total)
                    $display("  errors expected %0d actual %0d", want.error_total,
                             got.error_total);
                if (got.used_slots !== want.used_slots)
                    $display("  used expected %0d actual %0d", want.used_slots, got.used_slots);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    health_scoreboard sb;
    int  stall_cycles;
    bit  no_idle;      // long stretch with neither side idling

    bus_channel_health_table u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // result side: sample at rising edge, vary ready at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_reply(o_out);
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 8);
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            stall_cycles <= 0;
        else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles > 20000) begin
                $display("bus_channel_health_table test failed");
                $finish;
            end
        end
    end

    // one apb write, setup then access, lands on the access rising edge
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_CAN_LIMIT: sb.can_limit = val[15:0];
            REG_LIN_LIMIT: sb.lin_limit = val[15:0];
            REG_CAN_TYPE:  sb.can_code  = val[7:0];
            REG_LIN_TYPE:  sb.lin_code  = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // wait for every pending reply, then let the ring settle
    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    // one input transfer, with an optional random gap first; called at negedge
    task automatic send(t_in x);
        if (!no_idle)
            while ($urandom_range(99) < 8) @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= x;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(x);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_in make_req(logic [3:0] m, logic [7:0] ty, logic [7:0] id,
                                     logic [2:0] ws, logic [31:0] now);
        t_in x;
        x.mode = m; x.chan_type = ty; x.chan_id = id; x.wanted_state = ws;
        x.now_ms = now; x.auto_recover = 1'($urandom_range(1));
        x.recover_after_ms = $urandom;
        return x;
    endfunction

    // random request biased towards a small key set so channels get hit often
    function automatic t_in rand_req(logic [31:0] now);
        t_in x;
        int  r;
        x = make_req('0, '0, '0, '0, now);
        r = $urandom_range(99);
        if (r < 14)      x.mode = MODE_REGISTER;
        else if (r < 26) x.mode = MODE_SET_STATE;
        else if (r < 52) x.mode = MODE_REPORT;
        else if (r < 62) x.mode = MODE_RECOVERY;
        else if (r < 68) x.mode = MODE_GLOBAL;
        else if (r < 80) x.mode = MODE_TICK;
        else if (r < 88) x.mode = MODE_QUERY;
        else if (r < 93) x.mode = MODE_INIT;
        else if (r < 95) x.mode = MODE_SHUTDOWN;
        else             x.mode = 4'($urandom_range(15));
        if ($urandom_range(9) < 8) begin
            x.chan_type = 8'($urandom_range(3));
            x.chan_id   = 8'($urandom_range(7));
        end else begin
            x.chan_type = 8'($urandom);
            x.chan_id   = 8'($urandom);
        end
        x.wanted_state = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(4));
        if ($urandom_range(1)) x.recover_after_ms = $urandom_range(50);
        return x;
    endfunction

    initial begin
        t_in          x;
        logic [31:0]  now;
        sb          = new();
        no_idle     = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: small limits so states move quickly
        write_reg(REG_CAN_LIMIT, 32'd1);
        write_reg(REG_LIN_LIMIT, 32'd0);
        send(make_req(MODE_TICK, 8'd0, 8'd0, ST_UNINIT, 32'd5));    // tick before init
        send(make_req(MODE_INIT, 8'd0, 8'd0, ST_UNINIT, 32'd0));
        send(make_req(MODE_REGISTER, 8'd0, 8'd1, ST_UNINIT, 32'd0));
        send(make_req(MODE_REGISTER, 8'd0, 8'd1, ST_UNINIT, 32'd0)); // already present
        send(make_req(MODE_REGISTER, 8'd1, 8'd2, ST_UNINIT, 32'd0));
        send(make_req(MODE_REGISTER, 8'hFF, 8'hFF, ST_UNINIT, 32'd0));
        send(make_req(MODE_REPORT, 8'd0, 8'd1, ST_UNINIT, 32'd10));
        send(make_req(MODE_REPORT, 8'd0, 8'd1, ST_UNINIT, 32'hFFFF_FFF0)); // bus off
        send(make_req(MODE_REPORT, 8'd1, 8'd2, ST_UNINIT, 32'd11));        // lin passive
        send(make_req(MODE_REPORT, 8'hFF, 8'hFF, ST_UNINIT, 32'd12));      // other fails
        send(make_req(MODE_REPORT, 8'd9, 8'd9, ST_UNINIT, 32'd12));        // unknown
        x = make_req(MODE_RECOVERY, 8'd0, 8'd1, ST_UNINIT, 0);
        x.auto_recover = 1'b1;
        x.recover_after_ms = 32'd20;
        send(x);
        send(make_req(MODE_TICK, 8'd0, 8'd1, ST_UNINIT, 32'd3));   // wrapped, elapsed 19
        send(make_req(MODE_TICK, 8'd0, 8'd1, ST_UNINIT, 32'd4));   // elapsed 20, recovers
        send(make_req(MODE_SET_STATE, 8'd1, 8'd2, 3'd7, 32'd1));   // out of range
        send(make_req(MODE_SET_STATE, 8'd1, 8'd2, ST_PASSIVE, 32'd1)); // same state
        send(make_req(MODE_SET_STATE, 8'd1, 8'd2, ST_UNINIT, 32'd1));
        send(make_req(MODE_GLOBAL, 8'd0, 8'd1, 3'd5, 32'd2));
        send(make_req(MODE_GLOBAL, 8'd0, 8'd1, ST_FAILURE, 32'd2));
        send(make_req(MODE_QUERY, 8'd0, 8'd1, ST_UNINIT, 32'd2));
        send(make_req(4'd15, 8'd0, 8'd1, ST_UNINIT, 32'd2));
        for (int i = 0; i < 15; i++)                                // fill, then overflow
            send(make_req(MODE_REGISTER, 8'd7, 8'(i), ST_UNINIT, 32'd0));
        send(make_req(MODE_GLOBAL, 8'd7, 8'd0, ST_BUS_OFF, 32'd9)); // 16 events
        send(make_req(MODE_SHUTDOWN, 8'd0, 8'd1, ST_UNINIT, 32'd0));
        drain();

        // equal type codes: can rule wins; extreme limits
        write_reg(REG_CAN_TYPE, 32'd1);
        write_reg(REG_LIN_TYPE, 32'd1);
        write_reg(REG_CAN_LIMIT, 32'hFFFF);
        write_reg(REG_LIN_LIMIT, 32'hFFFF);
        send(make_req(MODE_REGISTER, 8'd1, 8'd0, ST_UNINIT, 32'd0));
        send(make_req(MODE_REPORT, 8'd1, 8'd0, ST_UNINIT, 32'd0));
        drain();

        // random phases over several settings
        now = 32'd0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_CAN_LIMIT, 32'd2);  write_reg(REG_LIN_LIMIT, 32'd1);
                    write_reg(REG_CAN_TYPE, 32'd0);   write_reg(REG_LIN_TYPE, 32'd1);
                end
                1: begin
                    write_reg(REG_CAN_LIMIT, 32'd0);  write_reg(REG_LIN_LIMIT, 32'd3);
                    write_reg(REG_CAN_TYPE, 32'd2);   write_reg(REG_LIN_TYPE, 32'd3);
                end
                2: begin
                    write_reg(REG_CAN_LIMIT, 32'd5);  write_reg(REG_LIN_LIMIT, 32'd0);
                    write_reg(REG_CAN_TYPE, 32'hFF);  write_reg(REG_LIN_TYPE, 32'd0);
                end
                default: begin
                    write_reg(REG_CAN_LIMIT, $urandom_range(4));
                    write_reg(REG_LIN_LIMIT, $urandom_range(4));
                    write_reg(REG_CAN_TYPE, $urandom_range(3));
                    write_reg(REG_LIN_TYPE, $urandom_range(3));
                end
            endcase
            no_idle = (ph == 1);
            send(make_req(MODE_INIT, 8'd0, 8'd0, ST_UNINIT, now));
            for (int n = 0; n < 110; n++) begin
                now = ($urandom_range(19) == 0) ? $urandom : now + $urandom_range(8);
                send(rand_req(now));
            end
            no_idle = 0;
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("bus_channel_health_table test passed");
        else
            $display("bus_channel_health_table test failed");
        $finish;
    end
endmodule
`default_nettype wire
